### hdl/jse_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// JSON string escaper package
// Shared constants, the character-run descriptor type and escape helpers.
// ----------------------------------------------------------------------------
package jse_pkg;

  // Longest run one input item can cause: quote, \u00xx, quote, colon.
  localparam int JSE_DESC_CHARS  = 9;
  localparam int JSE_CNT_W       = $clog2(JSE_DESC_CHARS + 1);
  localparam int JSE_QUEUE_DEPTH = 2;

  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LB    = 8'h62;
  localparam logic [7:0] CH_LF    = 8'h66;
  localparam logic [7:0] CH_LN    = 8'h6E;
  localparam logic [7:0] CH_LR    = 8'h72;
  localparam logic [7:0] CH_LT    = 8'h74;
  localparam logic [7:0] CH_LU    = 8'h75;
  localparam logic [7:0] CH_DEL   = 8'h7F;
  localparam logic [7:0] CH_NONE  = 8'h00;

  // Raw byte codes that have a two-character escape.
  localparam logic [7:0] RAW_BS  = 8'h08;
  localparam logic [7:0] RAW_TAB = 8'h09;
  localparam logic [7:0] RAW_LF  = 8'h0A;
  localparam logic [7:0] RAW_FF  = 8'h0C;
  localparam logic [7:0] RAW_CR  = 8'h0D;
  localparam logic [7:0] RAW_CTRL_END = 8'h20;

  // One queued run of output characters, first character in chars[0].
  typedef struct packed {
    logic [JSE_DESC_CHARS-1:0][7:0] chars;
    logic [JSE_CNT_W-1:0]           count;
  } jse_desc_t;

  // Second character of a short escape, or CH_NONE if there is none.
  function automatic logic [7:0] short_escape(input logic [7:0] b);
    logic [7:0] c;
    c = CH_NONE;
    unique case (b)
      RAW_BS:   c = CH_LB;
      RAW_TAB:  c = CH_LT;
      RAW_LF:   c = CH_LN;
      RAW_FF:   c = CH_LF;
      RAW_CR:   c = CH_LR;
      CH_QUOTE: c = CH_QUOTE;
      CH_SLASH: c = CH_SLASH;
      CH_BSL:   c = CH_BSL;
      default:  c = CH_NONE;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] hex_lower(input logic [3:0] v);
    logic [7:0] c;
    if (v < 4'd10) begin
      c = CH_ZERO + {4'b0000, v};
    end else begin
      c = CH_LA + {4'b0000, v} - 8'd10;
    end
    return c;
  endfunction

endpackage

### hdl/jse_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// JSON string escaper front end
// Classifies one input byte with its marks into a run descriptor.
// ----------------------------------------------------------------------------
module jse_front (
  input  logic [7:0]         data_byte,
  input  logic               first_of_string,
  input  logic               last_of_string,
  input  logic               empty_string,
  input  logic               key_mode,
  output jse_pkg::jse_desc_t desc
);
  import jse_pkg::*;

  logic [7:0]           short_c;
  logic [JSE_CNT_W-1:0] n;

  assign short_c = short_escape(data_byte);

  always_comb begin
    desc = '0;
    n    = '0;
    if (empty_string) begin
      desc.chars[0] = CH_QUOTE;
      desc.chars[1] = CH_QUOTE;
      n = JSE_CNT_W'(2);
      if (key_mode) begin
        desc.chars[n] = CH_COLON;
        n = n + 1'b1;
      end
    end else begin
      if (first_of_string) begin
        desc.chars[n] = CH_QUOTE;
        n = n + 1'b1;
      end
      if (short_c != CH_NONE) begin
        desc.chars[n]        = CH_BSL;
        desc.chars[n + 1'b1] = short_c;
        n = n + JSE_CNT_W'(2);
      end else if (data_byte < RAW_CTRL_END || data_byte == CH_DEL) begin
        desc.chars[n]              = CH_BSL;
        desc.chars[n + 1'b1]       = CH_LU;
        desc.chars[n + JSE_CNT_W'(2)] = CH_ZERO;
        desc.chars[n + JSE_CNT_W'(3)] = CH_ZERO;
        desc.chars[n + JSE_CNT_W'(4)] = hex_lower(data_byte[7:4]);
        desc.chars[n + JSE_CNT_W'(5)] = hex_lower(data_byte[3:0]);
        n = n + JSE_CNT_W'(6);
      end else begin
        desc.chars[n] = data_byte;
        n = n + 1'b1;
      end
      if (last_of_string) begin
        desc.chars[n] = CH_QUOTE;
        n = n + 1'b1;
        if (key_mode) begin
          desc.chars[n] = CH_COLON;
          n = n + 1'b1;
        end
      end
    end
    desc.count = n;
  end

endmodule

### hdl/jse_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// JSON string escaper descriptor queue
// Small FIFO between the classifier and the serializer.
// ----------------------------------------------------------------------------
module jse_queue #(
  parameter int DEPTH = jse_pkg::JSE_QUEUE_DEPTH
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           push,
  input  jse_pkg::jse_desc_t             push_desc,
  input  logic                           pop,
  output logic                           full,
  output logic                           head_valid,
  output jse_pkg::jse_desc_t             head_desc,
  output logic [$clog2(DEPTH+1)-1:0]     level
);
  import jse_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int LVL_W = $clog2(DEPTH + 1);

  jse_desc_t        entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;

  function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign full       = (level == LVL_W'(DEPTH));
  assign head_valid = (level != '0);
  assign head_desc  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_desc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= bump(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= bump(rd_ptr);
      end
      level <= level + LVL_W'(push) - LVL_W'(pop);
    end
  end

endmodule

### hdl/jse_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// JSON string escaper back end
// Walks the head run one character per ready cycle into an output register.
// ----------------------------------------------------------------------------
module jse_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               head_valid,
  input  jse_pkg::jse_desc_t head_desc,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [7:0]         out_char,
  output logic               end_of_run
);
  import jse_pkg::*;

  logic [JSE_CNT_W-1:0] idx;
  logic                 advance;
  logic                 at_end;

  assign advance = head_valid && (!out_valid || out_ready);
  assign at_end  = (idx == head_desc.count - 1'b1);
  assign pop     = advance && at_end;

  // Payload register: load the current character on each advance.
  always_ff @(posedge clk) begin
    if (advance) begin
      out_char   <= head_desc.chars[idx];
      end_of_run <= at_end;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (advance) begin
        out_valid <= 1'b1;
        idx       <= at_end ? '0 : idx + 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

### hdl/json_string_escaper_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// JSON string escaper core
// Turns a stream of string bytes into quoted, JSON-escaped text.
// ----------------------------------------------------------------------------
//
//  Channel   Dir  tdata          tuser                          tlast
//  s_axis    in   data_byte[7:0] first_of_string, empty_string,  last_of_string
//                                key_mode (bit 0 up)
//  m_axis    out  out_char[7:0]  -                              end_of_run
//
//  Each input item yields 1 to 9 output transfers, one per cycle while the
//  output is ready. A plain byte with no marks passes at one item per cycle;
//  an item that needs n characters holds the serializer for all n, and that
//  serializer, one output character per clock, sets the sustained rate.
//  The first output character is registered in the descriptor queue and then
//  in the output register before it is presented.
//  rst is synchronous and clears the queue pointers, the character index and
//  the output valid flag. A stalled output holds its character; the input
//  keeps taking items until the descriptor queue is full.
//
module json_string_escaper_core #(
  parameter int QUEUE_DEPTH = jse_pkg::JSE_QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] data_byte
  input  logic [2:0] s_axis_tuser,   // [0] first_of_string, [1] empty_string, [2] key_mode
  input  logic       s_axis_tlast,
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] out_char
  output logic       m_axis_tlast
);
  import jse_pkg::*;

  localparam int LVL_W = $clog2(QUEUE_DEPTH + 1);

  jse_desc_t        front_desc;
  jse_desc_t        head_desc;
  logic             q_full;
  logic             q_push;
  logic             q_pop;
  logic             head_valid;
  logic [LVL_W-1:0] q_level;

  // Classify the incoming byte into its full character run.
  jse_front u_front (
    .data_byte       (s_axis_tdata),
    .first_of_string (s_axis_tuser[0]),
    .last_of_string  (s_axis_tlast),
    .empty_string    (s_axis_tuser[1]),
    .key_mode        (s_axis_tuser[2]),
    .desc            (front_desc)
  );

  // Accept whenever the queue has room; the back end drains independently.
  assign s_axis_tready = !q_full;
  assign q_push        = s_axis_tvalid && s_axis_tready;

  jse_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_desc  (front_desc),
    .pop        (q_pop),
    .full       (q_full),
    .head_valid (head_valid),
    .head_desc  (head_desc),
    .level      (q_level)
  );

  // Serialize the head run into the output register.
  jse_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_desc  (head_desc),
    .pop        (q_pop),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_char   (m_axis_tdata),
    .end_of_run (m_axis_tlast)
  );

  // Queue level never passes its depth.
  a_level_bound: assert property (@(posedge clk) disable iff (rst)
    q_level <= LVL_W'(QUEUE_DEPTH))
    else $error("descriptor queue overflow");

  // Every queued run holds between one and nine characters.
  a_run_len: assert property (@(posedge clk) disable iff (rst)
    head_valid |-> (head_desc.count != '0 &&
                    head_desc.count <= JSE_CNT_W'(JSE_DESC_CHARS)))
    else $error("queued run length out of range");

  // With nothing queued, a taken output leaves the output empty.
  a_drain: assert property (@(posedge clk) disable iff (rst)
    (!head_valid && m_axis_tready) |=> !m_axis_tvalid)
    else $error("output valid without a queued run");

  // A pushed item is visible at the queue next cycle.
  a_push_seen: assert property (@(posedge clk) disable iff (rst)
    q_push |=> head_valid)
    else $error("pushed run not visible in queue");

endmodule

### test/tb_json_string_escaper_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// JSON string escaper core testbench
// Streams string bytes with first/last/empty/key marks into the core, predicts
// the quoted, escaped character run of every accepted transfer and checks each
// output transfer in order. Both sides idle at random; the output also holds
// off for a long stretch so the input backs up.
// ----------------------------------------------------------------------------
module tb_json_string_escaper_core;
  import jse_pkg::*;

  // One input transfer: a string byte and its marks.
  typedef struct {
    logic [7:0] data;
    bit         first;
    bit         last;
    bit         empty;
    bit         key;
  } str_byte_t;

  // One output character and its end-of-run flag.
  typedef struct {
    logic [7:0] ch;
    bit         eor;
  } esc_char_t;

  localparam int LONG_HOLD_CYCLES = 80;
  localparam int SETTLE_CYCLES    = 12;
  localparam int PHASE_ITEMS      = 38;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       s_axis_tvalid = 1'b0;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata = 8'h00;
  logic [2:0] s_axis_tuser = 3'b000;  // [0] first, [1] empty, [2] key
  logic       s_axis_tlast = 1'b0;
  logic       m_axis_tvalid;
  logic       m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;           // [7:0] out_char
  logic       m_axis_tlast;

  str_byte_t pending_bytes[$];
  esc_char_t expected_chars[$];
  str_byte_t cur_byte;
  bit        in_taken = 1'b0;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_request  = 0;
  int hold_left     = 0;

  int errors      = 0;
  int bytes_sent  = 0;
  int chars_seen  = 0;
  int runs_seen   = 0;
  int escapes_hit = 0;
  int closes_hit  = 0;

  json_string_escaper_core dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #1 clk = ~clk;

  // Lowercase hex digit of a nibble.
  function automatic logic [7:0] nibble_char(input logic [3:0] v);
    return (v < 4'd10) ? CH_ZERO + 8'(v) : CH_LA + 8'(v) - 8'd10;
  endfunction

  // Work out the character run of one accepted transfer and queue it.
  task automatic escape_item(input str_byte_t it);
    logic [7:0] run[$];
    logic [7:0] tail;
    bit         is_esc;
    tail   = CH_NONE;
    is_esc = 1'b0;
    if (it.empty) begin
      run.push_back(CH_QUOTE);
      run.push_back(CH_QUOTE);
      if (it.key) run.push_back(CH_COLON);
      closes_hit++;
    end else begin
      if (it.first) run.push_back(CH_QUOTE);
      case (it.data)
        RAW_BS:   tail = CH_LB;
        RAW_TAB:  tail = CH_LT;
        RAW_LF:   tail = CH_LN;
        RAW_FF:   tail = CH_LF;
        RAW_CR:   tail = CH_LR;
        CH_QUOTE: tail = CH_QUOTE;
        CH_SLASH: tail = CH_SLASH;
        CH_BSL:   tail = CH_BSL;
        default:  tail = CH_NONE;
      endcase
      if (tail != CH_NONE) begin
        run.push_back(CH_BSL);
        run.push_back(tail);
        is_esc = 1'b1;
      end else if (it.data < RAW_CTRL_END || it.data == CH_DEL) begin
        // no short form: \u00xx with lowercase hex
        run.push_back(CH_BSL);
        run.push_back(CH_LU);
        run.push_back(CH_ZERO);
        run.push_back(CH_ZERO);
        run.push_back(nibble_char(it.data[7:4]));
        run.push_back(nibble_char(it.data[3:0]));
        is_esc = 1'b1;
      end else begin
        run.push_back(it.data);
      end
      if (it.last) begin
        run.push_back(CH_QUOTE);
        if (it.key) run.push_back(CH_COLON);
        closes_hit++;
      end
    end
    if (is_esc) escapes_hit++;
    foreach (run[i]) expected_chars.push_back(esc_char_t'{ch: run[i],
                                                          eor: (i == run.size() - 1)});
  endtask

  // Input side: record accepted transfers at the rising edge and predict them.
  always @(posedge clk) begin
    if (!rst && s_axis_tvalid && s_axis_tready) begin
      escape_item(cur_byte);
      bytes_sent++;
      in_taken = 1'b1;
    end
  end

  // Driver: hold an offered byte until it is taken, then idle or offer the next.
  always @(negedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (s_axis_tvalid && !in_taken) begin
      // hold until accepted
    end else begin
      in_taken = 1'b0;
      if (pending_bytes.size() == 0 || $urandom_range(99) < send_idle_pct) begin
        s_axis_tvalid <= 1'b0;
      end else begin
        cur_byte = pending_bytes.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= cur_byte.data;
        s_axis_tuser  <= {cur_byte.key, cur_byte.empty, cur_byte.first};
        s_axis_tlast  <= cur_byte.last;
      end
    end
  end

  // Receiver: random back-pressure, plus a long hold-off on request.
  always @(negedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (hold_request > 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Monitor: compare each output transfer with the oldest expected character.
  always @(posedge clk) begin
    esc_char_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      chars_seen++;
      if (m_axis_tlast) runs_seen++;
      if (expected_chars.size() == 0) begin
        $error("unexpected output transfer: out_char=%h end_of_run=%b",
               m_axis_tdata, m_axis_tlast);
        errors++;
      end else begin
        want = expected_chars.pop_front();
        if (m_axis_tdata !== want.ch) begin
          $error("out_char: expected %h, got %h", want.ch, m_axis_tdata);
          errors++;
        end
        if (m_axis_tlast !== want.eor) begin
          $error("end_of_run: expected %b, got %b", want.eor, m_axis_tlast);
          errors++;
        end
      end
    end
  end

  task automatic add_byte(input logic [7:0] d, input bit f, input bit l,
                          input bit e, input bit k);
    pending_bytes.push_back('{data: d, first: f, last: l, empty: e, key: k});
  endtask

  // A mix of control codes, escaped specials and DEL, high, printable and any bytes.
  function automatic logic [7:0] pick_byte();
    logic [7:0] b;
    case ($urandom_range(6))
      0: b = 8'($urandom_range(31));
      1: case ($urandom_range(3))
           0: b = CH_QUOTE;
           1: b = CH_BSL;
           2: b = CH_SLASH;
           default: b = CH_DEL;
         endcase
      2: b = 8'($urandom_range(255, 128));
      3, 4: b = 8'($urandom_range(126, 32));
      default: b = 8'($urandom);
    endcase
    return b;
  endfunction

  // Queue about n_items bytes: mostly whole strings, some noise.
  task automatic queue_random(input int n_items);
    int n_queued;
    int len;
    n_queued = 0;
    while (n_queued < n_items) begin
      if ($urandom_range(99) < 15) begin
        // fields at random: broken strings, stray marks
        add_byte(8'($urandom), 1'($urandom_range(1)), 1'($urandom_range(1)),
                 ($urandom_range(7) == 0), 1'($urandom_range(1)));
        n_queued++;
      end else begin
        len = $urandom_range(6);
        if (len == 0) begin
          add_byte(8'($urandom), 1'($urandom_range(1)), 1'($urandom_range(1)), 1'b1,
                   1'($urandom_range(1)));
          n_queued++;
        end else begin
          for (int i = 0; i < len; i++) begin
            add_byte(pick_byte(), (i == 0), (i == len - 1), 1'b0,
                     1'($urandom_range(1)));
          end
          n_queued += len;
        end
      end
    end
  endtask

  // Let every queued byte go out and every expected character come back.
  task automatic drain();
    while (pending_bytes.size() != 0 || s_axis_tvalid || expected_chars.size() != 0) begin
      @(posedge clk);
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty strings, one-byte strings, every escape, range edges,
    // marks out of order, and the longest run.
    send_idle_pct = 29;
    recv_idle_pct = 54;
    add_byte(8'hFF, 1'b1, 1'b1, 1'b1, 1'b0);
    add_byte(8'h5A, 1'b0, 1'b0, 1'b1, 1'b1);
    add_byte(8'h41, 1'b1, 1'b1, 1'b0, 1'b0);
    add_byte(8'h42, 1'b1, 1'b1, 1'b0, 1'b1);
    add_byte(RAW_BS,   1'b1, 1'b0, 1'b0, 1'b1);
    add_byte(RAW_TAB,  1'b0, 1'b0, 1'b0, 1'b0);
    add_byte(RAW_LF,   1'b0, 1'b0, 1'b0, 1'b1);
    add_byte(RAW_FF,   1'b0, 1'b0, 1'b0, 1'b0);
    add_byte(RAW_CR,   1'b0, 1'b0, 1'b0, 1'b0);
    add_byte(CH_QUOTE, 1'b0, 1'b0, 1'b0, 1'b0);
    add_byte(CH_SLASH, 1'b0, 1'b0, 1'b0, 1'b0);
    add_byte(CH_BSL,   1'b0, 1'b1, 1'b0, 1'b0);
    add_byte(8'h00, 1'b1, 1'b0, 1'b0, 1'b0);
    add_byte(8'h1F, 1'b0, 1'b0, 1'b0, 1'b0);
    add_byte(8'h20, 1'b0, 1'b0, 1'b0, 1'b0);
    add_byte(CH_DEL, 1'b0, 1'b0, 1'b0, 1'b0);
    add_byte(8'h80, 1'b0, 1'b0, 1'b0, 1'b0);
    add_byte(8'hFF, 1'b0, 1'b1, 1'b0, 1'b1);
    add_byte(8'h7E, 1'b1, 1'b0, 1'b0, 1'b0);   // repeated first mark
    add_byte(8'h61, 1'b1, 1'b0, 1'b0, 1'b0);
    add_byte(8'h62, 1'b0, 1'b1, 1'b0, 1'b0);   // last mark twice in a row
    add_byte(8'h63, 1'b0, 1'b1, 1'b0, 1'b1);
    add_byte(8'h01, 1'b1, 1'b1, 1'b0, 1'b1);   // longest run: nine characters
    queue_random(PHASE_ITEMS);
    drain();

    // Sender mostly idle, receiver mostly ready; open with a long output
    // hold-off so the input backs up and stalls.
    send_idle_pct = 54;
    recv_idle_pct = 29;
    @(posedge clk);
    hold_request = LONG_HOLD_CYCLES;
    send_idle_pct = 0;
    queue_random(10);
    drain();
    send_idle_pct = 54;
    queue_random(PHASE_ITEMS);
    drain();

    // Full rate on both sides.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    queue_random(PHASE_ITEMS);
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Sent %0d string bytes (%0d escaped, %0d closing); checked %0d characters",
             bytes_sent, escapes_hit, closes_hit, chars_seen);
    $display("in %0d runs, under random and long output back-pressure", runs_seen);
    if (errors == 0 && expected_chars.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #400000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
